>>> rtl/core/mbse_pkg.sv
// Shared types, constants and helpers for the middle-button scroll emulator.
package mbse_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned SumW    = 18;
  localparam int unsigned ThreshW = 15;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [ThreshW-1:0] THRESH_RESET = ThreshW'(16);

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_DOWN  = 2'd1,
    KIND_MOVED = 2'd2,
    KIND_UP    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      buttons_present;
    logic                      middle_down;
    logic                      position_present;
    logic signed [CoordW-1:0]  pos_x;
    logic signed [CoordW-1:0]  pos_y;
  } event_t;

  typedef struct packed {
    logic                      scrolling;
    logic                      middle_held;
    logic signed [CoordW-1:0]  last_x;
    logic signed [CoordW-1:0]  last_y;
    logic signed [SumW-1:0]    sum_x;
    logic signed [SumW-1:0]    sum_y;
  } state_t;

  typedef struct packed {
    logic                      swallow;
    logic                      wheel_valid;
    logic signed [SumW-1:0]    wheel_dx;
    logic signed [SumW-1:0]    wheel_dy;
  } result_t;

  // clamp a one-bit-wider sum back into the accumulator range
  function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW:0] s);
    logic signed [SumW:0] hi;
    logic signed [SumW:0] lo;
    hi = (SumW+1)'((1 << (SumW-1)) - 1);
    lo = -hi - (SumW+1)'(1);
    if (s > hi) begin
      sat_sum = hi[SumW-1:0];
    end else if (s < lo) begin
      sat_sum = lo[SumW-1:0];
    end else begin
      sat_sum = s[SumW-1:0];
    end
  endfunction

endpackage

>>> rtl/core/mbse_step.sv
// Next-state and result logic for one mouse event.
module mbse_step (
  input  mbse_pkg::event_t                     ev,
  input  mbse_pkg::state_t                     st,
  input  logic [mbse_pkg::ThreshW-1:0]         threshold,
  output mbse_pkg::state_t                     st_nxt,
  output mbse_pkg::result_t                    res
);

  logic                              mid;
  logic signed [mbse_pkg::CoordW:0]  dx;
  logic signed [mbse_pkg::CoordW:0]  dy;
  logic signed [mbse_pkg::SumW-1:0]  sx;
  logic signed [mbse_pkg::SumW-1:0]  sy;
  logic signed [mbse_pkg::SumW:0]    sx_w;
  logic signed [mbse_pkg::SumW:0]    sy_w;
  logic signed [mbse_pkg::SumW:0]    thr;
  logic                              below;

  assign mid = ev.buttons_present & ev.middle_down;
  assign dx  = (mbse_pkg::CoordW+1)'(ev.pos_x) - (mbse_pkg::CoordW+1)'(st.last_x);
  assign dy  = (mbse_pkg::CoordW+1)'(ev.pos_y) - (mbse_pkg::CoordW+1)'(st.last_y);
  assign sx  = mbse_pkg::sat_sum((mbse_pkg::SumW+1)'(st.sum_x) + (mbse_pkg::SumW+1)'(dx));
  assign sy  = mbse_pkg::sat_sum((mbse_pkg::SumW+1)'(st.sum_y) + (mbse_pkg::SumW+1)'(dy));
  assign sx_w = (mbse_pkg::SumW+1)'(sx);
  assign sy_w = (mbse_pkg::SumW+1)'(sy);
  assign thr  = signed'({{(mbse_pkg::SumW+1-mbse_pkg::ThreshW){1'b0}}, threshold});
  assign below = (sx_w > -thr) && (sx_w < thr) && (sy_w > -thr) && (sy_w < thr);

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (ev.kind)
      mbse_pkg::KIND_OTHER: begin
      end
      mbse_pkg::KIND_UP: begin
        if (st.middle_held && !mid) begin
          st_nxt.scrolling   = 1'b0;
          st_nxt.middle_held = 1'b0;
          st_nxt.sum_x       = '0;
          st_nxt.sum_y       = '0;
          res.swallow        = 1'b1;
        end else if (!st.middle_held) begin
          st_nxt.scrolling = 1'b0;
        end
      end
      mbse_pkg::KIND_DOWN: begin
        if (!ev.buttons_present) begin
          st_nxt.scrolling = 1'b0;
        end else if (!mid) begin
          st_nxt.scrolling   = 1'b0;
          st_nxt.middle_held = 1'b0;
          st_nxt.sum_x       = '0;
          st_nxt.sum_y       = '0;
        end else if (ev.position_present) begin
          st_nxt.scrolling   = 1'b1;
          st_nxt.middle_held = 1'b1;
          st_nxt.last_x      = ev.pos_x;
          st_nxt.last_y      = ev.pos_y;
          st_nxt.sum_x       = '0;
          st_nxt.sum_y       = '0;
          res.swallow        = 1'b1;
        end
      end
      mbse_pkg::KIND_MOVED: begin
        if (!ev.buttons_present) begin
          st_nxt.scrolling = 1'b0;
        end else if (st.scrolling && ev.position_present) begin
          if (!mid) begin
            st_nxt.scrolling   = 1'b0;
            st_nxt.middle_held = 1'b0;
            st_nxt.sum_x       = '0;
            st_nxt.sum_y       = '0;
          end else begin
            st_nxt.last_x = ev.pos_x;
            st_nxt.last_y = ev.pos_y;
            res.swallow   = 1'b1;
            if (below) begin
              st_nxt.sum_x = sx;
              st_nxt.sum_y = sy;
            end else begin
              // threshold reached: flush both sums as one wheel step
              res.wheel_valid = 1'b1;
              res.wheel_dx    = sx;
              res.wheel_dy    = sy;
              st_nxt.sum_x    = '0;
              st_nxt.sum_y    = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/middle_button_scroll_emulator_unit.sv
// Top level of the middle-button scroll emulator: request registers and state.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   in_      | in_tvalid / in_tready | in_tuser kind, in_tdata event fields
//   out_     | out_tvalid/out_tready | out_tdata decision and wheel deltas
//   cfg_     | cfg_wr_en             | cfg_wr_data scroll threshold
//
// One request per cycle sustained while out_ accepts; a request passes the input
// register and then the result register on its way to out_, with the single
// state update between them. A stalled result register holds while the input
// register still takes one more request. Reset clears the gesture state and
// sets the threshold to 1.0 pixel.
module middle_button_scroll_emulator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // bit 0 buttons_present, 1 middle_down, 2 position_present,
  // 18:3 pos_x, 34:19 pos_y, 39:35 zero
  input  logic [mbse_pkg::InDataW-1:0]        in_tdata,
  // bits 1:0 kind
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // bit 0 swallow, 1 wheel_valid, 19:2 wheel_dx, 37:20 wheel_dy, 39:38 zero
  output logic [mbse_pkg::OutDataW-1:0]       out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [mbse_pkg::ThreshW-1:0]        cfg_wr_data
);

  localparam int unsigned CW = mbse_pkg::CoordW;

  logic                          in_vld_r;
  mbse_pkg::event_t              ev_r;
  logic                          out_vld_r;
  mbse_pkg::result_t             res_r;
  mbse_pkg::state_t              st_r;
  mbse_pkg::state_t              st_nxt;
  mbse_pkg::result_t             res_nxt;
  logic [mbse_pkg::ThreshW-1:0]  thresh_r;
  logic                          advance;
  mbse_pkg::event_t              ev_in;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  assign ev_in.kind             = mbse_pkg::kind_t'(in_tuser);
  assign ev_in.buttons_present  = in_tdata[0];
  assign ev_in.middle_down      = in_tdata[1];
  assign ev_in.position_present = in_tdata[2];
  assign ev_in.pos_x            = signed'(in_tdata[3 +: CW]);
  assign ev_in.pos_y            = signed'(in_tdata[3 + CW +: CW]);

  mbse_step u_step (
    .ev        (ev_r),
    .st        (st_r),
    .threshold (thresh_r),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
      thresh_r  <= mbse_pkg::THRESH_RESET;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ev_r <= ev_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = mbse_pkg::OutDataW'({res_r.wheel_dy, res_r.wheel_dx,
                                           res_r.wheel_valid, res_r.swallow});

endmodule

>>> sim/middle_button_scroll_emulator_unit_tb.sv
// Self-checking bench for the scroll emulator: queued mouse events, predicted decisions.
module middle_button_scroll_emulator_unit_tb;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int PerPhase   = 166;
  localparam int NumPhases  = 8;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [mbse_pkg::InDataW-1:0]    in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [mbse_pkg::OutDataW-1:0]   out_tdata;
  logic                            cfg_wr_en;
  logic [mbse_pkg::ThreshW-1:0]    cfg_wr_data;

  // pending mouse events and predicted decisions
  mbse_pkg::event_t  mouse_q[$];
  mbse_pkg::result_t decision_q[$];

  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic in_took = 1'b0;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;

  // predicted gesture state
  logic                                gest_scrolling = 1'b0;
  logic                                gest_held      = 1'b0;
  logic signed [mbse_pkg::CoordW-1:0]  anchor_x       = '0;
  logic signed [mbse_pkg::CoordW-1:0]  anchor_y       = '0;
  logic signed [mbse_pkg::SumW-1:0]    acc_x          = '0;
  logic signed [mbse_pkg::SumW-1:0]    acc_y          = '0;
  logic [mbse_pkg::ThreshW-1:0]        cur_thresh     = mbse_pkg::THRESH_RESET;

  middle_button_scroll_emulator_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_gesture();
    gest_scrolling = 1'b0;
    gest_held      = 1'b0;
    acc_x          = '0;
    acc_y          = '0;
  endfunction

  function automatic int clip_sum(input int v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic mbse_pkg::result_t emulate_event(input mbse_pkg::event_t ev);
    mbse_pkg::result_t r;
    logic    mid;
    int      t;
    int      nx;
    int      ny;
    r   = '0;
    mid = ev.buttons_present & ev.middle_down;
    t   = int'(cur_thresh);
    case (ev.kind)
      mbse_pkg::KIND_OTHER: ;
      mbse_pkg::KIND_UP: begin
        if (gest_held && !mid) begin
          drop_gesture();
          r.swallow = 1'b1;
        end else if (!gest_held) begin
          gest_scrolling = 1'b0;
        end
      end
      default: begin
        if (!ev.buttons_present) begin
          gest_scrolling = 1'b0;
        end else if (ev.kind == mbse_pkg::KIND_DOWN) begin
          if (!mid) begin
            drop_gesture();
          end else if (ev.position_present) begin
            gest_held      = 1'b1;
            gest_scrolling = 1'b1;
            anchor_x       = ev.pos_x;
            anchor_y       = ev.pos_y;
            acc_x          = '0;
            acc_y          = '0;
            r.swallow      = 1'b1;
          end
        end else if (gest_scrolling && ev.position_present) begin
          if (!mid) begin
            drop_gesture();
          end else begin
            nx = clip_sum(int'(acc_x) + int'($signed(ev.pos_x)) - int'(anchor_x));
            ny = clip_sum(int'(acc_y) + int'($signed(ev.pos_y)) - int'(anchor_y));
            anchor_x  = ev.pos_x;
            anchor_y  = ev.pos_y;
            acc_x     = mbse_pkg::SumW'(nx);
            acc_y     = mbse_pkg::SumW'(ny);
            r.swallow = 1'b1;
            // sums must sit strictly inside (-T, T) on both axes to keep accumulating
            if (!(nx > -t && nx < t && ny > -t && ny < t)) begin
              r.wheel_valid = 1'b1;
              r.wheel_dx    = acc_x;
              r.wheel_dy    = acc_y;
              acc_x         = '0;
              acc_y         = '0;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // driver: a request holds until taken, then the next one or an idle cycle
  always @(negedge clk) begin : driver
    mbse_pkg::event_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (mouse_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = mouse_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= {5'b0, nxt.pos_y, nxt.pos_x, nxt.position_present,
                      nxt.middle_down, nxt.buttons_present};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    out_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin : rx_hold_proc
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin : monitor
    mbse_pkg::event_t  ev;
    mbse_pkg::result_t got;
    mbse_pkg::result_t want;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_wr_en) cur_thresh = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        ev.kind             = mbse_pkg::kind_t'(in_tuser);
        ev.buttons_present  = in_tdata[0];
        ev.middle_down      = in_tdata[1];
        ev.position_present = in_tdata[2];
        ev.pos_x            = in_tdata[18:3];
        ev.pos_y            = in_tdata[34:19];
        decision_q.push_back(emulate_event(ev));
        accepted_cnt++;
      end
      if (out_tvalid && out_tready) begin
        got.swallow     = out_tdata[0];
        got.wheel_valid = out_tdata[1];
        got.wheel_dx    = out_tdata[19:2];
        got.wheel_dy    = out_tdata[37:20];
        if (decision_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        end else begin
          want = decision_q.pop_front();
          check_field("swallow", int'(want.swallow), int'(got.swallow));
          check_field("wheel_valid", int'(want.wheel_valid), int'(got.wheel_valid));
          check_field("wheel_dx", int'(want.wheel_dx), int'(got.wheel_dx));
          check_field("wheel_dy", int'(want.wheel_dy), int'(got.wheel_dy));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_ev(input mbse_pkg::kind_t k, input logic bp, input logic md,
                        input logic pp,
                        input logic signed [mbse_pkg::CoordW-1:0] x,
                        input logic signed [mbse_pkg::CoordW-1:0] y);
    mbse_pkg::event_t e;
    e.kind             = k;
    e.buttons_present  = bp;
    e.middle_down      = md;
    e.position_present = pp;
    e.pos_x            = x;
    e.pos_y            = y;
    mouse_q.push_back(e);
    issued_cnt++;
  endtask

  task automatic add_noise();
    add_ev(mbse_pkg::kind_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
  endtask

  // press, a run of moves with the middle button held, usually a release
  task automatic add_gesture();
    logic signed [mbse_pkg::CoordW-1:0] x;
    logic signed [mbse_pkg::CoordW-1:0] y;
    int span;
    x = 16'($urandom);
    y = 16'($urandom);
    add_ev(mbse_pkg::KIND_DOWN, 1'b1, 1'b1, 1'b1, x, y);
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 9) == 0) begin
        add_noise();
      end else begin
        case ($urandom_range(0, 3))
          0: span = 4;
          1: span = 32;
          2: span = 512;
          default: span = 32768;
        endcase
        x = x + 16'($urandom_range(0, 2 * span) - span);
        y = y + 16'($urandom_range(0, 2 * span) - span);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, $urandom_range(0, 15) != 0, x, y);
      end
    end
    case ($urandom_range(0, 4))
      0, 1: add_ev(mbse_pkg::KIND_UP, 1'b1, 1'b0, 1'($urandom_range(0, 1)), x, y);
      2: add_ev(mbse_pkg::KIND_UP, 1'b0, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), x, y);
      3: add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b0, 1'b1, x, y);
      default: add_ev(mbse_pkg::KIND_DOWN, 1'b1, 1'b0, 1'($urandom_range(0, 1)), x, y);
    endcase
  endtask

  // every request taken and answered, then the pipeline left to drain
  task automatic settle();
    while (accepted_cnt != issued_cnt || decision_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [mbse_pkg::ThreshW-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int goal;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = mbse_pkg::KIND_OTHER;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        1: set_threshold(mbse_pkg::ThreshW'(1));
        2: set_threshold(mbse_pkg::ThreshW'(32767));
        3: set_threshold(mbse_pkg::ThreshW'(0));
        4: set_threshold(mbse_pkg::ThreshW'(40));
        5: set_threshold(mbse_pkg::ThreshW'($urandom_range(1, 32767)));
        6: set_threshold(mbse_pkg::ThreshW'(300));
        7: set_threshold(mbse_pkg::THRESH_RESET);
        default: ;
      endcase
      @(posedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (ph == 2) hold_go = 1'b1;

      if (ph == 0) begin
        // directed part at the reset threshold of 1.0 pixel
        add_ev(mbse_pkg::KIND_OTHER, 1'b1, 1'b1, 1'b1, -16'sd1, -16'sd1);
        add_ev(mbse_pkg::KIND_UP,    1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_DOWN,  1'b1, 1'b1, 1'b0, 16'sd100, 16'sd100);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, 16'sd5, 16'sd5);
        add_ev(mbse_pkg::KIND_DOWN,  1'b1, 1'b1, 1'b1, -16'sd32768, -16'sd32768);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, -16'sd32760, -16'sd32768);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b0, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_UP,    1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_OTHER, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, 16'sd32767, 16'sd32767);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, -16'sd32768, -16'sd32768);
        // sum landing exactly on the threshold, then exactly on its negative
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, -16'sd32752, -16'sd32768);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, -16'sd32768, -16'sd32768);
        add_ev(mbse_pkg::KIND_MOVED, 1'b0, 1'b1, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b1, 1'b1, 16'sd900, 16'sd900);
        add_ev(mbse_pkg::KIND_UP,    1'b1, 1'b0, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_DOWN,  1'b1, 1'b1, 1'b1, 16'sd32767, 16'sd32767);
        add_ev(mbse_pkg::KIND_MOVED, 1'b1, 1'b0, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_DOWN,  1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_DOWN,  1'b1, 1'b0, 1'b1, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_DOWN,  1'b1, 1'b1, 1'b1, 16'sd48, -16'sd48);
        add_ev(mbse_pkg::KIND_UP,    1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0);
        add_ev(mbse_pkg::KIND_DOWN,  1'b0, 1'b1, 1'b1, 16'sd7, 16'sd7);
        add_ev(mbse_pkg::KIND_UP,    1'b1, 1'b1, 1'b0, 16'sd0, 16'sd0);
      end

      goal = issued_cnt + PerPhase;
      while (issued_cnt < goal) begin
        if ($urandom_range(0, 99) < 80) add_gesture();
        else add_noise();
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
